// ===== hw/rtl/srpd_pkg.sv =====
// Shared types and constants for the stripe row pattern detector.
// No dependencies; every other file imports this package.
package srpd_pkg;

  // Scan window over the columns of a row (stripe test column range).
  localparam logic [7:0] SCAN_FIRST_COL = 8'd30;
  localparam logic [7:0] SCAN_END_COL   = 8'd130;
  localparam logic [7:0] ROW_START_COL  = SCAN_FIRST_COL - 8'd2;
  localparam logic [7:0] SCAN_LO_COL    = SCAN_FIRST_COL + 8'd1;

  localparam logic [6:0]  CNT_MAX = 7'd127;
  localparam logic [15:0] RUN_MAX = 16'hFFFF;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_RIGHT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BLOCKS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BLOCKS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_SPAN        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ROWS        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_ROW      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_ROW         = 3'd7;

  localparam logic       RST_DIRECTION_RIGHT = 1'b0;
  localparam logic [5:0] RST_MIN_BLOCKS      = 6'd4;
  localparam logic [5:0] RST_MAX_BLOCKS      = 6'd18;
  localparam logic [4:0] RST_MAX_GAP         = 5'd10;
  localparam logic [6:0] RST_ROW_SPAN        = 7'd20;
  localparam logic [6:0] RST_MIN_ROWS        = 7'd3;
  localparam logic [6:0] RST_BOTTOM_ROW      = 7'd110;
  localparam logic [6:0] RST_TOP_ROW         = 7'd45;

  typedef struct packed {
    logic       pixel_white;
    logic [7:0] column;
    logic [6:0] row;
    logic       frame_end;
    logic       left_inflection;
    logic       right_inflection;
  } srpd_in_t;

  typedef struct packed {
    logic        detected;
    logic [15:0] frames_in_row;
    logic [6:0]  rows_found;
    logic [6:0]  first_row;
  } srpd_out_t;

  typedef struct packed {
    logic       direction_right;
    logic [5:0] min_blocks;
    logic [5:0] max_blocks;
    logic [4:0] max_gap;
    logic [6:0] row_span;
    logic [6:0] min_rows;
    logic [6:0] bottom_row;
    logic [6:0] top_row;
  } srpd_cfg_t;

  typedef struct packed {
    logic [2:0]  pixel_history;
    logic [7:0]  fall_column;
    logic [7:0]  rise_column;
    logic [6:0]  stripe_count;
    logic [6:0]  row_count;
    logic [6:0]  start_row;
    logic        row_finished;
    logic [15:0] frame_run;
  } srpd_state_t;

endpackage

// ===== hw/rtl/srpd_step.sv =====
// One-pixel update of the detector state and the frame-end result.
// Pure combinational; depends on srpd_pkg.
module srpd_step import srpd_pkg::*; (
  input  srpd_state_t st,
  input  srpd_cfg_t   cfg,
  input  srpd_in_t    item,
  output srpd_state_t st_nxt,
  output srpd_out_t   res
);

  always_comb begin
    logic        in_rows;
    logic        scan;
    logic [7:0]  j;
    logic        pm2, pm1, p0;
    logic [7:0]  fall, rise;
    logic [8:0]  diff;
    logic        stripe;
    logic [6:0]  cnt;
    logic        finished;
    logic [6:0]  start;
    logic [7:0]  row_gap;
    logic [6:0]  rows;
    logic        qualify;
    logic        hit;
    logic [15:0] run;

    in_rows  = (item.row >= cfg.top_row) && (item.row <= cfg.bottom_row);
    cnt      = st.stripe_count;
    finished = st.row_finished;
    // New row inside the scan band: restart the stripe count.
    if (in_rows && item.column == ROW_START_COL) begin
      cnt      = '0;
      finished = 1'b0;
    end
    scan = in_rows && !finished &&
           item.column >= SCAN_LO_COL && item.column <= SCAN_END_COL;

    j   = item.column - 8'd1;
    pm2 = st.pixel_history[2];
    pm1 = st.pixel_history[1];
    p0  = st.pixel_history[0];

    fall    = st.fall_column;
    rise    = st.rise_column;
    start   = st.start_row;
    rows    = st.row_count;
    diff    = '0;
    row_gap = '0;
    stripe  = 1'b0;
    qualify = 1'b0;

    if (scan) begin
      if (pm1 && pm2 && !p0) fall = j;
      if (!pm1 && p0 && item.pixel_white && fall != 8'd0) rise = j;
      diff   = {1'b0, rise} - {1'b0, fall};
      stripe = (fall != 8'd0) && (rise != 8'd0) && !diff[8] && (diff != 9'd0) &&
               (diff[7:0] <= {3'd0, cfg.max_gap});
      if (stripe) begin
        fall = '0;
        rise = '0;
        if (cnt != CNT_MAX) cnt = cnt + 7'd1;
      end
      qualify = (cnt >= {1'b0, cfg.min_blocks}) && (cnt <= {1'b0, cfg.max_blocks});
      if (qualify) begin
        if (start == 7'd0) start = item.row;
        row_gap = {1'b0, start} - {1'b0, item.row};
        if (row_gap[7]) row_gap = 8'd0 - row_gap;
        // Rows too far from the first qualifying row keep scanning.
        if (row_gap <= {1'b0, cfg.row_span}) begin
          if (rows != CNT_MAX) rows = rows + 7'd1;
          cnt      = '0;
          finished = 1'b1;
        end
      end
    end

    hit = (rows >= cfg.min_rows) &&
          ((item.left_inflection && !cfg.direction_right) ||
           (item.right_inflection && cfg.direction_right));
    run = st.frame_run;
    if (item.frame_end) begin
      if (!hit) run = '0;
      else if (run != RUN_MAX) run = run + 16'd1;
    end

    res.detected      = hit;
    res.frames_in_row = run;
    res.rows_found    = rows;
    res.first_row     = start;

    if (item.frame_end) begin
      st_nxt           = '0;
      st_nxt.frame_run = run;
    end else begin
      st_nxt.pixel_history = {st.pixel_history[1:0], item.pixel_white};
      st_nxt.fall_column   = fall;
      st_nxt.rise_column   = rise;
      st_nxt.stripe_count  = cnt;
      st_nxt.row_count     = rows;
      st_nxt.start_row     = start;
      st_nxt.row_finished  = finished;
      st_nxt.frame_run     = run;
    end
  end

endmodule

// ===== hw/rtl/stripe_row_pattern_detector.sv =====
// Top level of the stripe row pattern detector: handshakes, config registers,
// state and result registers. Depends on srpd_pkg and srpd_step.
//
//  port group | direction | beat contents                    | when
//  -----------+-----------+----------------------------------+-------------------------
//  in_*       | in        | srpd_in_t, one pixel per beat     | in_valid & in_ready
//  out_*      | out       | srpd_out_t, one per frame         | out_valid & out_ready
//  cfg_*      | in        | register index + data, no wait    | cfg_we
//
// Throughput: one pixel per clock except while a frame-end beat stalls; a beat
// is held in the input register, and its state update and frame result are
// registered when it fires. The state recurrence (srpd_step) loops only via st_r.
// Reset (rst_n low, synchronous) clears state, valids and loads config defaults.
// Stalls: a frame-end beat waits in the input register only while the result
// register holds an untaken result; other pixels advance regardless of out_ready.
module stripe_row_pattern_detector import srpd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  srpd_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output srpd_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  srpd_in_t    in_r;
  logic        in_vld_r;
  srpd_out_t   out_r;
  logic        out_vld_r;
  srpd_cfg_t   cfg_r;
  srpd_state_t st_r;
  srpd_state_t st_nxt;
  srpd_out_t   res;
  logic        out_free;
  logic        fire;

  // Result slot is free if empty or being drained this cycle.
  assign out_free = !out_vld_r || out_ready;
  // Process the held beat; a frame end needs a free result slot.
  assign fire     = in_vld_r && (!in_r.frame_end || out_free);
  assign in_ready = !in_vld_r || fire;

  srpd_step u_step (
    .st     (st_r),
    .cfg    (cfg_r),
    .item   (in_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
  end

  // Detector state: advance on every processed beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

  // Result register: load on a processed frame end, drop once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire && in_r.frame_end) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_r.frame_end) begin
      out_r <= res;
    end
  end

  // Configuration registers; each write keeps only the register's own width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.direction_right <= RST_DIRECTION_RIGHT;
      cfg_r.min_blocks      <= RST_MIN_BLOCKS;
      cfg_r.max_blocks      <= RST_MAX_BLOCKS;
      cfg_r.max_gap         <= RST_MAX_GAP;
      cfg_r.row_span        <= RST_ROW_SPAN;
      cfg_r.min_rows        <= RST_MIN_ROWS;
      cfg_r.bottom_row      <= RST_BOTTOM_ROW;
      cfg_r.top_row         <= RST_TOP_ROW;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_DIRECTION_RIGHT: cfg_r.direction_right <= cfg_wdata[0];
        CFG_MIN_BLOCKS:      cfg_r.min_blocks      <= cfg_wdata[5:0];
        CFG_MAX_BLOCKS:      cfg_r.max_blocks      <= cfg_wdata[5:0];
        CFG_MAX_GAP:         cfg_r.max_gap         <= cfg_wdata[4:0];
        CFG_ROW_SPAN:        cfg_r.row_span        <= cfg_wdata;
        CFG_MIN_ROWS:        cfg_r.min_rows        <= cfg_wdata;
        CFG_BOTTOM_ROW:      cfg_r.bottom_row      <= cfg_wdata;
        CFG_TOP_ROW:         cfg_r.top_row         <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

// ===== hw/rtl/srpd_checker.sv =====
// Port-level checks for the stripe row pattern detector, bound to the top.
// Depends on srpd_pkg.
module srpd_checker import srpd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input srpd_out_t out_data
);

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // A detected frame always has a nonzero run.
  a_hit_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.detected |-> out_data.frames_in_row != 16'd0)
    else $error("detected frame with zero run");

  // A missed frame drops the run.
  a_miss_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.detected |-> out_data.frames_in_row == 16'd0)
    else $error("run not cleared on missed frame");

  // No result beat right after reset.
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind stripe_row_pattern_detector srpd_checker u_srpd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/sv/srpd_frame_scoreboard.sv =====
`timescale 1ns / 1ps
// Frame verdict scoreboard for the stripe row pattern detector testbench.
// Depends on srpd_pkg for the beat, result and register types.
package srpd_tb_pkg;
  import srpd_pkg::*;

  class stripe_frame_sb;
    srpd_cfg_t   regs;
    srpd_state_t scan;
    srpd_out_t   verdicts_due[$];
    int unsigned mismatches;
    int unsigned verdicts_seen;
    int unsigned frames_flagged;

    function new();
      regs.direction_right = RST_DIRECTION_RIGHT;
      regs.min_blocks      = RST_MIN_BLOCKS;
      regs.max_blocks      = RST_MAX_BLOCKS;
      regs.max_gap         = RST_MAX_GAP;
      regs.row_span        = RST_ROW_SPAN;
      regs.min_rows        = RST_MIN_ROWS;
      regs.bottom_row      = RST_BOTTOM_ROW;
      regs.top_row         = RST_TOP_ROW;
      scan           = '0;
      mismatches     = 0;
      verdicts_seen  = 0;
      frames_flagged = 0;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_DIRECTION_RIGHT: regs.direction_right = data[0];
        CFG_MIN_BLOCKS:      regs.min_blocks      = data[5:0];
        CFG_MAX_BLOCKS:      regs.max_blocks      = data[5:0];
        CFG_MAX_GAP:         regs.max_gap         = data[4:0];
        CFG_ROW_SPAN:        regs.row_span        = data;
        CFG_MIN_ROWS:        regs.min_rows        = data;
        CFG_BOTTOM_ROW:      regs.bottom_row      = data;
        CFG_TOP_ROW:         regs.top_row         = data;
        default: ;
      endcase
    endfunction

    // Everything but the frame run goes back to zero at frame end.
    function void clear_frame();
      logic [15:0] run;
      run = scan.frame_run;
      scan = '0;
      scan.frame_run = run;
    endfunction

    // Stripe test of column j: window j-2..j+1, cur is the pixel of j+1.
    function void test_stripe_at(input logic [7:0] j, input logic [6:0] row,
                                 input logic cur);
      logic p_m2, p_m1, p_0;
      int   width, row_gap;
      p_m2 = scan.pixel_history[2];
      p_m1 = scan.pixel_history[1];
      p_0  = scan.pixel_history[0];
      if (p_m2 && p_m1 && !p_0) scan.fall_column = j;
      if (!p_m1 && p_0 && cur && scan.fall_column != 8'd0) scan.rise_column = j;
      width = int'(scan.rise_column) - int'(scan.fall_column);
      if (scan.fall_column != 8'd0 && scan.rise_column != 8'd0 && width >= 1 &&
          width <= int'(regs.max_gap)) begin
        scan.fall_column = 8'd0;
        scan.rise_column = 8'd0;
        if (scan.stripe_count != CNT_MAX) scan.stripe_count++;
      end
      if (scan.stripe_count >= regs.min_blocks && scan.stripe_count <= regs.max_blocks) begin
        if (scan.start_row == 7'd0) scan.start_row = row;
        row_gap = int'(scan.start_row) - int'(row);
        if (row_gap < 0) row_gap = -row_gap;
        if (row_gap > int'(regs.row_span)) return;
        if (scan.row_count != CNT_MAX) scan.row_count++;
        scan.stripe_count = 7'd0;
        scan.row_finished = 1'b1;
      end
    endfunction

    function void note_pixel(input srpd_in_t px);
      logic      in_band, hit;
      srpd_out_t v;
      in_band = px.row >= regs.top_row && px.row <= regs.bottom_row;
      if (in_band) begin
        if (px.column == ROW_START_COL) begin
          scan.stripe_count = 7'd0;
          scan.row_finished = 1'b0;
        end
        if (!scan.row_finished && px.column >= SCAN_LO_COL && px.column <= SCAN_END_COL)
          test_stripe_at(px.column - 8'd1, px.row, px.pixel_white);
      end
      scan.pixel_history = {scan.pixel_history[1:0], px.pixel_white};
      if (!px.frame_end) return;
      hit = scan.row_count >= regs.min_rows &&
            ((px.left_inflection && !regs.direction_right) ||
             (px.right_inflection && regs.direction_right));
      if (hit) begin
        if (scan.frame_run != RUN_MAX) scan.frame_run++;
      end else begin
        scan.frame_run = 16'd0;
      end
      v.detected      = hit;
      v.frames_in_row = scan.frame_run;
      v.rows_found    = scan.row_count;
      v.first_row     = scan.start_row;
      verdicts_due.push_back(v);
      clear_frame();
    endfunction

    function void cmp_field(input string name, input logic [15:0] want,
                            input logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(input srpd_out_t got);
      srpd_out_t want;
      if (verdicts_due.size() == 0) begin
        $display("%0t: result with no frame pending, expected none, actual %0d/%0d/%0d/%0d",
                 $time, got.detected, got.frames_in_row, got.rows_found, got.first_row);
        mismatches++;
        return;
      end
      want = verdicts_due.pop_front();
      verdicts_seen++;
      if (want.detected) frames_flagged++;
      cmp_field("detected", 16'(want.detected), 16'(got.detected));
      cmp_field("frames_in_row", want.frames_in_row, got.frames_in_row);
      cmp_field("rows_found", 16'(want.rows_found), 16'(got.rows_found));
      cmp_field("first_row", 16'(want.first_row), 16'(got.first_row));
    endfunction
  endclass

endpackage

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Top-level testbench of stripe_row_pattern_detector: clock, reset, pixel and
// result handshakes, register writes, directed and random frame stimulus.
// Depends on srpd_pkg, srpd_tb_pkg (frame verdict scoreboard) and the RTL.
module tb_top;
  import srpd_pkg::*;
  import srpd_tb_pkg::*;

  localparam int IDLE_PCT      = 26;
  localparam int PHASE_BEATS   = 120;
  localparam int PHASE_FRAMES  = 3;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 10;
  localparam int N_SETTINGS    = 8;
  localparam int QUIET_PHASE   = 3;   // no idling on either side here
  localparam int FLOOD_PHASE   = 2;   // rows_found saturation frame here

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  srpd_in_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  srpd_out_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  stripe_frame_sb sb = new();
  bit             idle_en = 1'b1;
  srpd_in_t       beat_q[$];
  int unsigned    beats_sent;
  int unsigned    frames_sent;
  int unsigned    settings_used;

  stripe_row_pattern_detector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run (about 2k beats).
  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Result side: check each accepted beat, then pick the next ready value.
  // Signals are read at the edge before any nonblocking update lands.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_result(out_data);
      out_ready <= !idle_en || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  function automatic srpd_in_t pixel_beat(input logic pix, input logic [7:0] col,
                                          input logic [6:0] row);
    srpd_in_t b;
    b.pixel_white      = pix;
    b.column           = col;
    b.row              = row;
    b.frame_end        = 1'b0;
    // Inflection bits only count on the frame end beat; toggle them anyway.
    b.left_inflection  = $urandom_range(0, 1);
    b.right_inflection = $urandom_range(0, 1);
    return b;
  endfunction

  function automatic srpd_cfg_t setting(input int dir, input int minb, input int maxb,
                                        input int gap, input int span, input int minr,
                                        input int bot, input int top);
    srpd_cfg_t s;
    s.direction_right = dir[0];
    s.min_blocks      = minb[5:0];
    s.max_blocks      = maxb[5:0];
    s.max_gap         = gap[4:0];
    s.row_span        = span[6:0];
    s.min_rows        = minr[6:0];
    s.bottom_row      = bot[6:0];
    s.top_row         = top[6:0];
    return s;
  endfunction

  // Random setting, biased toward thresholds that rows actually reach.
  function automatic srpd_cfg_t random_setting();
    int bot, span;
    bot  = $urandom_range(20, 119);
    span = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 119) : $urandom_range(0, 8);
    return setting($urandom_range(0, 1), $urandom_range(0, 4), $urandom_range(2, 63),
                   $urandom_range(1, 31), span, $urandom_range(0, 4), bot,
                   $urandom_range(0, bot));
  endfunction

  // Drive one pixel beat: optional idle cycles first, then hold valid and
  // payload until the block takes it.
  task automatic send_beat(input srpd_in_t px);
    bit taken;
    while (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = in_ready;
    end
    sb.note_pixel(px);
    beats_sent++;
  endtask

  // Mark the last queued beat as frame end, then push the whole frame.
  task automatic send_frame(input logic linf, input logic rinf);
    int last;
    last = beat_q.size() - 1;
    beat_q[last].frame_end        = 1'b1;
    beat_q[last].left_inflection  = linf;
    beat_q[last].right_inflection = rinf;
    foreach (beat_q[i]) send_beat(beat_q[i]);
    beat_q.delete();
    frames_sent++;
  endtask

  task automatic send_random_frame();
    send_frame($urandom_range(0, 9) < 6, $urandom_range(0, 9) < 6);
  endtask

  // Queue n pixels of one row from column c0, MSB of bits first.
  task automatic queue_pattern(input logic [6:0] row, input logic [7:0] c0, input int n,
                               input logic [15:0] bits);
    int i;
    for (i = 0; i < n; i++) beat_q.push_back(pixel_beat(bits[n-1-i], c0 + 8'(i), row));
  endtask

  // Rows climb upward (row numbers fall); each row alternates white and dark
  // runs, the dark ones up to a little past max_gap, with sparse pixel flips.
  task automatic build_stripe_frame();
    int   n_rows, r, c0, c1, c, k, run, dark_max;
    logic white;
    n_rows = $urandom_range(1, 5);
    if (sb.regs.top_row <= sb.regs.bottom_row && $urandom_range(0, 9) < 8)
      r = $urandom_range(sb.regs.top_row, sb.regs.bottom_row);
    else
      r = $urandom_range(0, 119);
    dark_max = int'(sb.regs.max_gap) + 2;
    for (k = 0; k < n_rows && r >= 0; k++) begin
      c0 = ($urandom_range(0, 9) < 8) ? int'(ROW_START_COL) : $urandom_range(0, 40);
      c1 = c0 + (($urandom_range(0, 19) == 0) ? $urandom_range(100, 131)
                                              : $urandom_range(6, 30));
      if (c1 > 159) c1 = 159;
      white = 1'b1;
      run   = $urandom_range(1, 4);
      for (c = c0; c <= c1; c++) begin
        beat_q.push_back(pixel_beat(white ^ ($urandom_range(0, 19) == 0), c[7:0], r[6:0]));
        run--;
        if (run == 0) begin
          white = !white;
          run   = white ? $urandom_range(2, 5) : $urandom_range(1, dark_max);
        end
      end
      r -= ($urandom_range(0, 3) == 0) ? 2 : 1;
    end
  endtask

  // A few beats anywhere in the field ranges, in no particular order.
  task automatic build_noise_frame();
    repeat ($urandom_range(1, 6))
      beat_q.push_back(pixel_beat($urandom_range(0, 1), $urandom_range(0, 159),
                                  $urandom_range(0, 119)));
  endtask

  // With min_blocks at zero every row start plus one scanned column counts a
  // row; 130 of them on one row push rows_found into saturation.
  task automatic build_flood_frame();
    int r;
    r = $urandom_range(sb.regs.top_row, sb.regs.bottom_row);
    repeat (130) begin
      beat_q.push_back(pixel_beat($urandom_range(0, 1), ROW_START_COL, r[6:0]));
      beat_q.push_back(pixel_beat($urandom_range(0, 1), SCAN_LO_COL, r[6:0]));
    end
    beat_q.push_back(pixel_beat(1'b1, SCAN_END_COL, r[6:0]));
  endtask

  // Drop valid and hold off until every frame verdict is back, then let the
  // pipeline settle before touching registers.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic apply_setting(input srpd_cfg_t s);
    put_reg(CFG_DIRECTION_RIGHT, CFG_DATA_W'(s.direction_right));
    put_reg(CFG_MIN_BLOCKS, CFG_DATA_W'(s.min_blocks));
    put_reg(CFG_MAX_BLOCKS, CFG_DATA_W'(s.max_blocks));
    put_reg(CFG_MAX_GAP, CFG_DATA_W'(s.max_gap));
    put_reg(CFG_ROW_SPAN, s.row_span);
    put_reg(CFG_MIN_ROWS, s.min_rows);
    put_reg(CFG_BOTTOM_ROW, s.bottom_row);
    put_reg(CFG_TOP_ROW, s.top_row);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  initial begin
    srpd_cfg_t   phases[N_SETTINGS];
    int unsigned beat_mark, frame_mark;
    int          p;

    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= CFG_DIRECTION_RIGHT;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: lone frame end beats at both corners of the fields.
    beat_q.push_back(pixel_beat(1'b0, 8'd0, 7'd0));
    send_frame(1'b0, 1'b0);
    beat_q.push_back(pixel_beat(1'b1, 8'd159, 7'd119));
    send_frame(1'b1, 1'b1);

    wait_idle();
    apply_setting(setting(0, 1, 1, 1, 0, 1, 119, 0));
    // One width-1 stripe on row zero: row zero counts but never latches.
    queue_pattern(7'd0, ROW_START_COL, 6, 16'b110110);
    send_frame(1'b1, 1'b0);
    // Width-2 stripe is past max_gap; only the unused side's flag is up.
    queue_pattern(7'd119, ROW_START_COL, 6, 16'b110011);
    send_frame(1'b0, 1'b1);
    // Qualifying row 100, frame ends on the next row up with both flags.
    queue_pattern(7'd100, ROW_START_COL, 5, 16'b11011);
    beat_q.push_back(pixel_beat(1'b0, ROW_START_COL, 7'd99));
    send_frame(1'b1, 1'b1);

    // Register settings include the defaults, the extremes, an inverted block
    // range with an empty row band, and two random ones.
    phases[0] = setting(RST_DIRECTION_RIGHT, RST_MIN_BLOCKS, RST_MAX_BLOCKS, RST_MAX_GAP,
                        RST_ROW_SPAN, RST_MIN_ROWS, RST_BOTTOM_ROW, RST_TOP_ROW);
    phases[1] = setting(1, 1, 3, 31, 119, 1, 119, 0);
    phases[2] = setting(0, 0, 0, 1, 0, 0, 60, 50);
    phases[3] = setting(1, 63, 63, 31, 119, 119, 119, 0);
    phases[4] = setting(0, 2, 5, 6, 3, 2, 90, 80);
    phases[5] = setting(1, 3, 1, 10, 20, 0, 30, 40);
    phases[6] = random_setting();
    phases[7] = random_setting();

    for (p = 0; p < N_SETTINGS; p++) begin
      // The sender pauses here until every verdict is back.
      wait_idle();
      apply_setting(phases[p]);
      idle_en    = (p != QUIET_PHASE);
      beat_mark  = beats_sent;
      frame_mark = frames_sent;
      if (p == FLOOD_PHASE) begin
        build_flood_frame();
        send_frame(1'b1, 1'b0);
      end
      while (beats_sent - beat_mark < PHASE_BEATS || frames_sent - frame_mark < PHASE_FRAMES) begin
        if ($urandom_range(0, 3) == 0) build_noise_frame();
        else                           build_stripe_frame();
        send_random_frame();
      end
    end

    idle_en = 1'b1;
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d pixel beats in %0d frames across %0d register settings.",
             beats_sent, frames_sent, settings_used);
    $display("Compared %0d frame verdicts, %0d of them with the pattern flagged.",
             sb.verdicts_seen, sb.frames_flagged);
    if (sb.mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
